@@ rtl/pvc_pkg.sv @@
// shared types and constants for the pid voltage clamp step block
package pvc_pkg;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_UPPER = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_TAU   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TARGET      = 3'd6;

    // field widths fixed by the register map
    localparam int GAIN_W = 16;
    localparam int CLAMP_W = 32;
    localparam int TAU_W = 16;
    localparam int STEP_W = 16;
    localparam int DRIVE_W = 32;

    // multiplier operand of the shared unit: a gain or a zero-extended step
    localparam int MUL_BITS = 17;

    typedef logic t_mdu_op;
    localparam t_mdu_op MDU_MUL = 1'b0;
    localparam t_mdu_op MDU_DIV = 1'b1;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_ctl;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  prop_gain;
        logic signed [GAIN_W-1:0]  integ_gain;
        logic signed [GAIN_W-1:0]  deriv_gain;
        logic signed [CLAMP_W-1:0] integ_upper;
        logic signed [CLAMP_W-1:0] integ_lower;
        logic [TAU_W-1:0]          deriv_tau;
    } t_cfg;

endpackage

@@ rtl/pvc_if.sv @@
// request and result channel interfaces of the pid voltage clamp step block
interface pvc_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [15:0]                   time_step;
    logic signed [SAMPLE_BITS-1:0] v_measured;

    modport source (output valid, output time_step, output v_measured, input ready);
    modport sink (input valid, input time_step, input v_measured, output ready);
endinterface

interface pvc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_current;
    logic               saturated;

    modport source (output valid, output drive_current, output saturated, input ready);
    modport sink (input valid, input drive_current, input saturated, output ready);
endinterface

@@ rtl/pvc_regs.sv @@
// apb configuration registers of the pid voltage clamp step block
module pvc_regs import pvc_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,
    output t_cfg                          o_cfg,
    output logic signed [SAMPLE_BITS-1:0] o_target
);

    t_cfg                          r_cfg;
    logic signed [SAMPLE_BITS-1:0] r_target;
    logic [REG_IDX_W-1:0]          idx;
    logic                          wr;

    assign idx = paddr[PADDR_W-1:2];
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.integ_upper <= 32'sd1;
            r_cfg.integ_lower <= -32'sd1;
            r_cfg.deriv_tau   <= 16'd1;
            r_target          <= '0;
        end else if (wr) begin
            case (idx)
                REG_PROP_GAIN:   r_cfg.prop_gain   <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  r_cfg.deriv_gain  <= pwdata[GAIN_W-1:0];
                REG_INTEG_UPPER: r_cfg.integ_upper <= pwdata[CLAMP_W-1:0];
                REG_INTEG_LOWER: r_cfg.integ_lower <= pwdata[CLAMP_W-1:0];
                REG_DERIV_TAU:   r_cfg.deriv_tau   <= pwdata[TAU_W-1:0];
                REG_TARGET:      r_target          <= pwdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP_GAIN:   prdata = {{(PDATA_W-GAIN_W){r_cfg.prop_gain[GAIN_W-1]}},
                                       r_cfg.prop_gain};
            REG_INTEG_GAIN:  prdata = {{(PDATA_W-GAIN_W){r_cfg.integ_gain[GAIN_W-1]}},
                                       r_cfg.integ_gain};
            REG_DERIV_GAIN:  prdata = {{(PDATA_W-GAIN_W){r_cfg.deriv_gain[GAIN_W-1]}},
                                       r_cfg.deriv_gain};
            REG_INTEG_UPPER: prdata = r_cfg.integ_upper;
            REG_INTEG_LOWER: prdata = r_cfg.integ_lower;
            REG_DERIV_TAU:   prdata = {{(PDATA_W-TAU_W){1'b0}}, r_cfg.deriv_tau};
            REG_TARGET:      prdata = {{(PDATA_W-SAMPLE_BITS){r_target[SAMPLE_BITS-1]}},
                                       r_target};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
    assign o_target = r_target;

endmodule

@@ rtl/pvc_mdu.sv @@
// shared shift-add multiplier and restoring divider, one bit per cycle
module pvc_mdu import pvc_pkg::*; #(
    parameter int W = 49
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mdu_ctl            i_ctl,
    input  logic [W-1:0]        i_a,
    input  logic [MUL_BITS-1:0] i_b,
    output logic                o_done,
    output logic [W-1:0]        o_result
);

    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(MUL_BITS - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(W - 1);

    logic                r_busy;
    logic                r_done;
    t_mdu_op             r_op;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_opa;
    logic [MUL_BITS-1:0] r_opb;

    logic          is_div;
    logic          last;
    logic          sub;
    logic [W-1:0]  rem_sh;
    logic [W-1:0]  add_x;
    logic [W-1:0]  add_y;
    logic [W:0]    add_s;
    logic          ge;

    assign is_div = (r_op == MDU_DIV);
    assign last = is_div ? (r_cnt == DIV_LAST) : (r_cnt == MUL_LAST);
    // the top multiplier bit weighs negative, so the final partial product is subtracted
    assign sub = is_div || last;
    assign rem_sh = {r_acc[W-2:0], r_opa[W-1]};
    assign add_x = is_div ? rem_sh : r_acc;
    assign add_y = is_div ? {{(W-MUL_BITS){1'b0}}, r_opb} : r_opa;
    assign add_s = {1'b0, add_x} + {1'b0, add_y ^ {W{sub}}} + {{W{1'b0}}, sub};
    // carry out of the subtract: remainder is at least the divisor
    assign ge = add_s[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_cnt <= '0;
            r_acc <= '0;
            r_opb <= i_b;
            if (i_ctl.op == MDU_DIV) begin
                // floor division: divide the magnitude of n or of -(n+1)
                r_neg <= i_a[W-1];
                r_opa <= i_a[W-1] ? ~i_a : i_a;
            end else begin
                r_neg <= 1'b0;
                r_opa <= i_a;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (is_div) begin
                r_acc <= ge ? add_s[W-1:0] : rem_sh;
                r_opa <= {r_opa[W-2:0], ge};
            end else begin
                if (r_opb[0]) begin
                    r_acc <= add_s[W-1:0];
                end
                r_opa <= {r_opa[W-2:0], 1'b0};
                r_opb <= {1'b0, r_opb[MUL_BITS-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_result = is_div ? (r_neg ? ~r_opa : r_opa) : r_acc;

endmodule

@@ rtl/pid_voltage_clamp_step.sv @@
// top level of the pid voltage clamp step block: sequencer, integrator and output stage
//
// usage
//   i_req (sink) takes one request per sample: time_step and the measured voltage
//   v_measured. o_rsp (source) returns one result per request: drive_current, which is
//   -15 times the sum of the proportional, integral and derivative terms, saturated
//   to 32 bits, and the saturated flag. gains, integrator clamps, tau and the target
//   voltage are written through the apb port while no request is in flight.
// sequence
//   a request is taken only while the sequencer is idle. the integrator update runs in
//   S_ACC and S_CLAMP, then four multiplies run on the shared shift-add unit and the
//   floor division by tau follows on the same unit, which is W bits wide (49 at the
//   default widths).
// reset
//   synchronous, active low: integrator and last voltage clear, registers take their
//   documented defaults, no result is pending.
// stalls
//   the result sits in an output register while the receiver holds ready low; the
//   next request is still taken and computed, and the sequencer waits in its final
//   step until the output register frees up.
module pid_voltage_clamp_step import pvc_pkg::*; #(
    parameter int SAMPLE_BITS    = 16,
    parameter int INTEG_BITS     = 32,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pvc_in_if.sink             i_req,
    pvc_out_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // shared unit width: holds every product, shifted multiplicand and dividend
    localparam int WI = GAIN_W + INTEG_BITS;
    localparam int WD = SAMPLE_BITS + 35 - GAIN_FRAC_BITS;
    localparam int W  = (WI > WD ? WI : WD) + 1;
    // integrator sum width, wide enough to compare against the 32-bit clamps
    localparam int MX = INTEG_BITS > SAMPLE_BITS + 1 ? INTEG_BITS : SAMPLE_BITS + 1;
    localparam int SW = (MX > CLAMP_W ? MX : CLAMP_W) + 1;
    localparam int PW = W + 2;
    localparam int TW = W + 6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ACC   = 4'd1;
    localparam logic [3:0] S_CLAMP = 4'd2;
    localparam logic [3:0] S_MP    = 4'd3;
    localparam logic [3:0] S_MI    = 4'd4;
    localparam logic [3:0] S_MD    = 4'd5;
    localparam logic [3:0] S_MS    = 4'd6;
    localparam logic [3:0] S_DV    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    t_cfg                          cfg;
    logic signed [SAMPLE_BITS-1:0] target;

    logic [3:0]                    r_state;
    logic                          r_run;
    logic [STEP_W-1:0]             r_step;
    logic signed [SAMPLE_BITS-1:0] r_v;
    logic signed [SAMPLE_BITS:0]   r_err;
    logic signed [SAMPLE_BITS+1:0] r_dv;
    logic signed [SW-1:0]          r_sum;
    logic signed [INTEG_BITS-1:0]  r_accum;
    logic signed [SAMPLE_BITS-1:0] r_last;
    logic signed [PW-1:0]          r_pid;
    logic signed [W-1:0]           r_ds;
    logic                          r_out_valid;
    logic signed [DRIVE_W-1:0]     r_drive;
    logic                          r_sat;

    t_mdu_ctl            mdu_ctl;
    logic [W-1:0]        mdu_a;
    logic [MUL_BITS-1:0] mdu_b;
    logic                mdu_done;
    logic [W-1:0]        mdu_res;

    logic                  accept;
    logic                  unit_state;
    logic signed [W-1:0]   res_s;
    logic signed [W-1:0]   term_sh;
    logic signed [PW-1:0]  term_ext;
    logic signed [PW-1:0]  res_ext;
    logic signed [SW-1:0]  up_s;
    logic signed [SW-1:0]  lo_s;
    logic signed [SW-1:0]  imax_s;
    logic signed [SW-1:0]  imin_s;
    logic signed [SW-1:0]  clamped;
    logic signed [SW-1:0]  n_accum;
    logic signed [TW-1:0]  pid_ext;
    logic signed [TW-1:0]  total;
    logic                  sat_hi;
    logic                  sat_lo;
    logic                  out_free;
    logic [TAU_W-1:0]      tau_eff;

    pvc_regs #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_target (target)
    );

    pvc_mdu #(
        .W(W)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mdu_ctl),
        .i_a      (mdu_a),
        .i_b      (mdu_b),
        .o_done   (mdu_done),
        .o_result (mdu_res)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept = i_req.valid && (r_state == S_IDLE);

    // a zero tau divides as one
    assign tau_eff = (cfg.deriv_tau == '0) ? TAU_W'(1) : cfg.deriv_tau;

    // operand selection for the shared unit, one product or quotient per state
    assign unit_state = (r_state == S_MP) || (r_state == S_MI) || (r_state == S_MD) ||
                        (r_state == S_MS) || (r_state == S_DV);
    assign mdu_ctl.start = unit_state && !r_run;
    assign mdu_ctl.op = (r_state == S_DV) ? MDU_DIV : MDU_MUL;

    always_comb begin
        case (r_state)
            S_MP: begin
                mdu_a = {{(W-SAMPLE_BITS-1){r_err[SAMPLE_BITS]}}, r_err};
                mdu_b = {cfg.prop_gain[GAIN_W-1], cfg.prop_gain};
            end
            S_MI: begin
                mdu_a = {{(W-INTEG_BITS){r_accum[INTEG_BITS-1]}}, r_accum};
                mdu_b = {cfg.integ_gain[GAIN_W-1], cfg.integ_gain};
            end
            S_MD: begin
                mdu_a = {{(W-SAMPLE_BITS-2){r_dv[SAMPLE_BITS+1]}}, r_dv};
                mdu_b = {cfg.deriv_gain[GAIN_W-1], cfg.deriv_gain};
            end
            S_MS: begin
                mdu_a = r_ds;
                mdu_b = {1'b0, r_step};
            end
            S_DV: begin
                mdu_a = r_ds;
                mdu_b = {1'b0, tau_eff};
            end
            default: begin
                mdu_a = '0;
                mdu_b = '0;
            end
        endcase
    end

    // gain products are q8.8: arithmetic shift gives the floor
    assign res_s = mdu_res;
    assign term_sh = res_s >>> GAIN_FRAC_BITS;
    assign term_ext = {{2{term_sh[W-1]}}, term_sh};
    assign res_ext = {{2{res_s[W-1]}}, res_s};

    // integrator clamp, upper bound tested first, then the integrator's own range
    assign up_s = {{(SW-CLAMP_W){cfg.integ_upper[CLAMP_W-1]}}, cfg.integ_upper};
    assign lo_s = {{(SW-CLAMP_W){cfg.integ_lower[CLAMP_W-1]}}, cfg.integ_lower};
    assign imax_s = {{(SW-INTEG_BITS+1){1'b0}}, {(INTEG_BITS-1){1'b1}}};
    assign imin_s = ~imax_s;
    assign clamped = (r_sum > up_s) ? up_s : ((r_sum < lo_s) ? lo_s : r_sum);
    assign n_accum = (clamped > imax_s) ? imax_s : ((clamped < imin_s) ? imin_s : clamped);

    // -15 * sum as sum - 16 * sum, then clip to 32 bits
    assign pid_ext = {{(TW-PW){r_pid[PW-1]}}, r_pid};
    assign total = pid_ext - (pid_ext <<< 4);
    assign sat_hi = !total[TW-1] && (|total[TW-2:DRIVE_W-1]);
    assign sat_lo = total[TW-1] && !(&total[TW-2:DRIVE_W-1]);
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= 1'b0;
            r_accum     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (mdu_ctl.start) begin
                r_run <= 1'b1;
            end else if (mdu_done) begin
                r_run <= 1'b0;
            end

            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_accum <= n_accum[INTEG_BITS-1:0];
                    r_last  <= r_v;
                    r_state <= S_MP;
                end
                S_MP: begin
                    if (mdu_done) begin
                        r_state <= S_MI;
                    end
                end
                S_MI: begin
                    if (mdu_done) begin
                        r_state <= S_MD;
                    end
                end
                S_MD: begin
                    if (mdu_done) begin
                        r_state <= S_MS;
                    end
                end
                S_MS: begin
                    if (mdu_done) begin
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    if (mdu_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step <= i_req.time_step;
            r_v    <= i_req.v_measured;
            r_err  <= {target[SAMPLE_BITS-1], target} -
                      {i_req.v_measured[SAMPLE_BITS-1], i_req.v_measured};
            // derivative acts on the measurement
            r_dv   <= {{2{i_req.v_measured[SAMPLE_BITS-1]}}, i_req.v_measured} -
                      {{2{r_last[SAMPLE_BITS-1]}}, r_last};
        end
        if (r_state == S_ACC) begin
            r_sum <= {{(SW-INTEG_BITS){r_accum[INTEG_BITS-1]}}, r_accum} +
                     {{(SW-SAMPLE_BITS-1){r_err[SAMPLE_BITS]}}, r_err};
        end
        if (mdu_done) begin
            case (r_state)
                S_MP: r_pid <= term_ext;
                S_MI: r_pid <= r_pid + term_ext;
                S_MD: r_ds  <= term_sh;
                S_MS: r_ds  <= res_s;
                S_DV: r_pid <= r_pid + res_ext;
                default: ;
            endcase
        end
        if ((r_state == S_FIN) && out_free) begin
            r_sat <= sat_hi || sat_lo;
            if (sat_hi) begin
                r_drive <= {1'b0, {(DRIVE_W-1){1'b1}}};
            end else if (sat_lo) begin
                r_drive <= {1'b1, {(DRIVE_W-1){1'b0}}};
            end else begin
                r_drive <= total[DRIVE_W-1:0];
            end
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.drive_current = r_drive;
    assign o_rsp.saturated = r_sat;

    // the unit reports completion only for an operation the sequencer launched
    assert property (@(posedge i_clk) disable iff (!i_rst_n) mdu_done |-> r_run)
        else $error("shared unit finished without a pending operation");

    // an accepted request starts the integrator update
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_ACC))
        else $error("accepted request did not start the sequence");

    // a clipped result sits at one of the 32-bit limits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.saturated) |->
        (o_rsp.drive_current == 32'sh7fffffff || o_rsp.drive_current == 32'sh80000000))
        else $error("saturated flag set on an unclipped result");

    // a finished result with a free output register is presented next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_out_valid) |=> (o_rsp.valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule
